@@ sv/jph_pkg.sv @@
// shared types, constants and arctangent table for the joystick polar heading block
`timescale 1ns / 1ps

package jph_pkg;

  localparam int POS_W      = 12;   // stored axis, 1/16 percent, -1600..1600
  localparam int SQ_W       = 24;   // sum of squares and square root registers
  localparam int VEC_W      = 36;   // cordic vector registers
  localparam int ACC_W      = 26;   // angle accumulator, degree * 2^16
  localparam int IDX_W      = 5;    // step index, up to 24 table entries
  localparam int SQRT_STEPS = 12;   // one result bit per step over a 24-bit radicand
  localparam int VEC_SHIFT  = 20;
  localparam int HEADING_MAX = 2880;

  localparam logic [2:0] AXIS_X = 3'd0;
  localparam logic [2:0] AXIS_Y = 3'd1;

  localparam logic FUNC_AXIS = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic signed [ACC_W-1:0] QUARTER_TURN = 26'sd5898240;  // 90 * 65536
  localparam logic [SQ_W-1:0] SQRT_FIRST_BIT = 24'h400000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_INIT,
    ST_ITER,
    ST_FINISH
  } jph_state_t;

  typedef struct packed {
    logic             load_x;
    logic             load_y;
    logic             square;
    logic             init;
    logic             sqrt_step;
    logic             cordic_step;
    logic [IDX_W-1:0] step_idx;
    logic             finish;
  } jph_cmd_t;

  typedef struct packed {
    logic axes_zero;
    logic out_hold;
  } jph_status_t;

  // atan(2^-i) in degree * 2^16, rounded
  function automatic logic [21:0] atan_entry(input logic [IDX_W-1:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/jph_ctrl.sv @@
// controller: sequences axis loads, squaring, the shared iteration loop and result hand-off
`timescale 1ns / 1ps

module jph_ctrl import jph_pkg::*; #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        func,
  input  logic [2:0]  axis_select,
  input  jph_status_t status,
  output logic        s_tready,
  output jph_cmd_t    cmd
);

  localparam int STEPS = (ANGLE_ITERATIONS > SQRT_STEPS) ? ANGLE_ITERATIONS : SQRT_STEPS;

  jph_state_t state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    s_tready   = 1'b0;
    cmd        = '0;
    cmd.step_idx = cnt;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (func == FUNC_AXIS) begin
            cmd.load_x = (axis_select == AXIS_X);
            cmd.load_y = (axis_select == AXIS_Y);
          end else if (!status.axes_zero) begin
            state_next = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_INIT;
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        cnt_next   = '0;
        state_next = ST_ITER;
      end
      ST_ITER: begin
        cmd.sqrt_step   = (cnt < IDX_W'(SQRT_STEPS));
        cmd.cordic_step = (cnt < IDX_W'(ANGLE_ITERATIONS));
        cnt_next        = cnt + 1'b1;
        if (cnt == IDX_W'(STEPS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait while an earlier result still sits in the output register
        if (!status.out_hold) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/jph_datapath.sv @@
// datapath: axis scaling, squares, iterative square root, cordic vectoring and output register
`timescale 1ns / 1ps

module jph_datapath import jph_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  jph_cmd_t           cmd,
  input  logic signed [15:0] axis_value,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_wdata,
  input  logic               m_tready,
  output logic               m_tvalid,
  output logic signed [12:0] heading,
  output logic [10:0]        magnitude,
  output jph_status_t        status
);

  logic signed [POS_W-1:0] x_pos, y_pos;
  logic [10:0]             limit;

  logic [22:0]             sq_x, sq_y;
  logic [SQ_W-1:0]         rem, root, bitv;
  logic signed [VEC_W-1:0] va, vb;
  logic signed [ACC_W-1:0] acc;

  logic signed [27:0]      scaled;
  logic signed [POS_W-1:0] pos_new;
  logic signed [23:0]      px, py;
  logic [SQ_W-1:0]         trial;
  logic signed [VEC_W-1:0] a0, b0, da, db;
  logic signed [ACC_W-1:0] step_angle, h_round;
  logic signed [13:0]      h_full;
  logic signed [12:0]      h_clamp;
  logic [12:0]             mag_round;
  logic [10:0]             mag_clamp;

  // round half up of value * 1600 / 32768
  assign scaled  = 28'(axis_value) * 28'sd1600 + 28'sd16384;
  assign pos_new = scaled[26:15];

  assign px = x_pos * x_pos;
  assign py = y_pos * y_pos;

  assign trial = root + bitv;

  assign a0 = -(VEC_W'(y_pos) <<< VEC_SHIFT);
  assign b0 = VEC_W'(x_pos) <<< VEC_SHIFT;
  assign da = vb >>> cmd.step_idx;
  assign db = va >>> cmd.step_idx;
  assign step_angle = signed'(ACC_W'(atan_entry(cmd.step_idx)));

  assign h_round = acc + 26'sd2048;
  assign h_full  = h_round[ACC_W-1:12];

  always_comb begin
    if (h_full > 14'sd2880) begin
      h_clamp = 13'(HEADING_MAX);
    end else if (h_full < -14'sd2880) begin
      h_clamp = -13'(HEADING_MAX);
    end else begin
      h_clamp = h_full[12:0];
    end
  end

  // remainder holds s - r*r, round up when it exceeds r
  assign mag_round = root[12:0] + 13'(rem > root);
  assign mag_clamp = (mag_round > 13'(limit)) ? limit : mag_round[10:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      x_pos <= '0;
      y_pos <= '0;
      limit <= 11'd1600;
    end else begin
      if (cmd.load_x) x_pos <= pos_new;
      if (cmd.load_y) y_pos <= pos_new;
      if (cfg_we) limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq_x <= px[22:0];
      sq_y <= py[22:0];
    end
    if (cmd.init) begin
      rem  <= SQ_W'(sq_x) + SQ_W'(sq_y);
      root <= '0;
      bitv <= SQRT_FIRST_BIT;
    end else if (cmd.sqrt_step) begin
      if (rem >= trial) begin
        rem  <= rem - trial;
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  // pre-rotate the rear half plane by a quarter turn, then vector b toward zero
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      if (a0 < 0) begin
        if (b0 >= 0) begin
          va  <= b0;
          vb  <= -a0;
          acc <= QUARTER_TURN;
        end else begin
          va  <= -b0;
          vb  <= a0;
          acc <= -QUARTER_TURN;
        end
      end else begin
        va  <= a0;
        vb  <= b0;
        acc <= '0;
      end
    end else if (cmd.cordic_step) begin
      if (vb > 0) begin
        va  <= va + da;
        vb  <= vb - db;
        acc <= acc + step_angle;
      end else begin
        va  <= va - da;
        vb  <= vb + db;
        acc <= acc - step_angle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      heading   <= h_clamp;
      magnitude <= mag_clamp;
    end
  end

  assign status.axes_zero = (x_pos == '0) && (y_pos == '0);
  assign status.out_hold  = m_tvalid && !m_tready;

endmodule

@@ sv/joystick_polar_heading_core.sv @@
// top level: joystick axes to heading and clamped magnitude
//
//  channel  dir  signals                       contents (lowest bit first)
//  s        in   s_tvalid s_tready s_tdata     axis_select[2:0], axis_value[18:3], zero pad
//                s_tuser                       func: 0 axis sample, 1 tick
//  m        out  m_tvalid m_tready m_tdata     heading[12:0], magnitude[23:13]
//  cfg      in   cfg_we cfg_wdata              magnitude_limit[10:0]
//
// an axis beat or a tick with both axes zero is taken straight from idle; a tick with a result
// runs squaring, init and the shared iteration loop, whose step count is the larger of
// ANGLE_ITERATIONS and SQRT_STEPS; square root and cordic steps run side by side in it
// a finished result sits in the output register; axis beats are taken meanwhile and
// the next result waits in its last step until the register is free
// rst is synchronous: axes clear to zero, limit returns to 1600
`timescale 1ns / 1ps

module joystick_polar_heading_core import jph_pkg::*; #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // axis_select[2:0], axis_value[18:3]
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // heading[12:0], magnitude[23:13]
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);

  jph_cmd_t           cmd;
  jph_status_t        status;
  logic signed [12:0] heading;
  logic [10:0]        magnitude;

  jph_ctrl #(
    .ANGLE_ITERATIONS(ANGLE_ITERATIONS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .func        (s_tuser),
    .axis_select (s_tdata[2:0]),
    .status      (status),
    .s_tready    (s_tready),
    .cmd         (cmd)
  );

  jph_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .axis_value (signed'(s_tdata[18:3])),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .heading    (heading),
    .magnitude  (magnitude),
    .status     (status)
  );

  assign m_tdata = {magnitude, heading};

endmodule

@@ sv/jph_checker.sv @@
// port-level checks for the joystick polar heading core, bound to the top level
`timescale 1ns / 1ps

module jph_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // a stalled result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[12:0]) <= 13'sd2880) && ($signed(m_tdata[12:0]) >= -13'sd2880))
    else $error("heading out of range");

  // a new result only appears after a busy cycle of the computation
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without a computation");

  a_reset_state: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("block not idle after reset");

endmodule

bind joystick_polar_heading_core jph_checker u_jph_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/testbench.sv @@
// testbench for joystick_polar_heading_core: directed and random axis/tick beats, predicted readings
`timescale 1ns / 1ps

module testbench;
  import jph_pkg::*;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int LIMIT_AT_RESET = 1600;
  localparam int SETTLE_CYCLES = ANGLE_ITERATIONS + 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 120;
  localparam logic [2:0] AXIS_FIRST_UNUSED = 3'd2;
  localparam logic [2:0] AXIS_LAST_UNUSED = 3'd7;

  // atan(2^-i) in degree * 2^16
  localparam longint ATAN_STEP [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic [10:0]        magnitude;
    logic signed [12:0] heading;
  } reading_t;

  class heading_scoreboard;
    int x_pct;
    int y_pct;
    int mag_limit;
    reading_t readings_q[$];
    int mismatches;

    function new();
      x_pct = 0;
      y_pct = 0;
      mag_limit = LIMIT_AT_RESET;
      mismatches = 0;
    endfunction

    // Q1.15 deflection to 1/16 percent, round half up
    function int axis_to_pct(logic signed [15:0] value);
      return int'((longint'(value) * 1600 + 16384) >>> 15);
    endfunction

    function reading_t polar_reading(int x, int y);
      reading_t r;
      longint a, b, acc, da, db, t, h;
      int sum, root, trial, bitpos, i;
      sum = x * x + y * y;
      root = 0;
      for (bitpos = 11; bitpos >= 0; bitpos--) begin
        trial = root | (1 << bitpos);
        if (trial * trial <= sum) root = trial;
      end
      if (sum - root * root > root) root++;
      r.magnitude = 11'((root > mag_limit) ? mag_limit : root);
      // vector (-y, x): forward lies on the positive a axis
      a = longint'(-y) <<< 20;
      b = longint'(x) <<< 20;
      acc = 0;
      if (a < 0) begin
        if (b >= 0) begin
          t = a; a = b; b = -t; acc = 90 * 65536;
        end else begin
          t = a; a = -b; b = t; acc = -90 * 65536;
        end
      end
      for (i = 0; i < ANGLE_ITERATIONS && i < 24; i++) begin
        da = b >>> i;
        db = a >>> i;
        if (b > 0) begin
          a += da; b -= db; acc += ATAN_STEP[i];
        end else begin
          a -= da; b += db; acc -= ATAN_STEP[i];
        end
      end
      h = (acc + 2048) >>> 12;
      if (h > HEADING_MAX) h = HEADING_MAX;
      if (h < -HEADING_MAX) h = -HEADING_MAX;
      r.heading = 13'(h);
      return r;
    endfunction

    function void note_beat(logic func, logic [2:0] sel, logic signed [15:0] value);
      if (func == FUNC_AXIS) begin
        if (sel == AXIS_X) x_pct = axis_to_pct(value);
        else if (sel == AXIS_Y) y_pct = axis_to_pct(value);
      end else if (x_pct != 0 || y_pct != 0) begin
        readings_q.push_back(polar_reading(x_pct, y_pct));
      end
    endfunction

    function void mismatch(string what, int want, int got);
      if (mismatches < 10)
        $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
      mismatches++;
    endfunction

    function void check_result(logic [23:0] data);
      reading_t want, got;
      got = reading_t'(data);
      if (readings_q.size() == 0) begin
        mismatch("unexpected beat, heading", 0, got.heading);
      end else begin
        want = readings_q.pop_front();
        if (got.heading !== want.heading) mismatch("heading", want.heading, got.heading);
        if (got.magnitude !== want.magnitude)
          mismatch("magnitude", want.magnitude, got.magnitude);
      end
    endfunction

    function int pending();
      return readings_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;    // axis_select[2:0], axis_value[18:3]
  logic        s_tuser = 1'b0;  // func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // heading[12:0], magnitude[23:13]
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;

  heading_scoreboard board;
  int src_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;
  int items_sent = 0;
  int cycle_count = 0;

  joystick_polar_heading_core #(
    .ANGLE_ITERATIONS(ANGLE_ITERATIONS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      m_tready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_beat(s_tuser, s_tdata[2:0], $signed(s_tdata[18:3]));
      if (m_tvalid && m_tready) board.check_result(m_tdata);
    end
  end

  task automatic send_beat(logic func, logic [2:0] sel, logic [15:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= {5'b0, value, sel};
    do @(posedge clk); while (!s_tready);
    if (func == FUNC_TICK || sel == AXIS_X || sel == AXIS_Y) items_sent++;
  endtask

  // operands of a tick are random, the block must not look at them
  task automatic send_tick();
    send_beat(FUNC_TICK, 3'($urandom), 16'($urandom));
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'($urandom_range(40)) - 16'd20;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_group();
    int kind;
    kind = $urandom_range(99);
    if (kind < 70) begin
      send_beat(FUNC_AXIS, AXIS_X, pick_value());
      send_beat(FUNC_AXIS, AXIS_Y, pick_value());
      send_tick();
    end else if (kind < 85) begin
      send_beat(FUNC_AXIS, $urandom_range(1) ? AXIS_Y : AXIS_X, pick_value());
      send_tick();
    end else if (kind < 92) begin
      // stick back at center
      send_beat(FUNC_AXIS, AXIS_X, 16'h0000);
      send_beat(FUNC_AXIS, AXIS_Y, 16'h0000);
      send_tick();
    end else begin
      send_beat(FUNC_AXIS, 3'($urandom_range(AXIS_LAST_UNUSED, AXIS_FIRST_UNUSED)),
                16'($urandom));
      send_tick();
    end
  endtask

  // drop valid and wait until the block has delivered everything
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(int lim);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= 11'(lim);
    board.mag_limit = lim;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int ph;
    int target;
    bit paused;
    board = new();
    paused = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset limit
    send_beat(FUNC_TICK, AXIS_Y, 16'h8000);   // both axes zero: nothing comes out
    send_beat(FUNC_AXIS, AXIS_X, 16'h7FFF);
    send_tick();                              // full right
    send_beat(FUNC_AXIS, AXIS_Y, 16'h8000);
    send_tick();                              // forward right, length over the limit
    send_beat(FUNC_AXIS, AXIS_X, 16'h8000);
    send_tick();
    send_beat(FUNC_AXIS, AXIS_X, 16'h0000);
    send_tick();                              // straight forward
    send_beat(FUNC_AXIS, AXIS_Y, 16'h7FFF);
    send_tick();                              // straight back
    send_beat(FUNC_AXIS, AXIS_Y, 16'h0000);
    send_tick();
    send_beat(FUNC_AXIS, AXIS_FIRST_UNUSED, 16'h7FFF);
    send_beat(FUNC_AXIS, AXIS_LAST_UNUSED, 16'h8000);
    send_tick();                              // unused axes leave the stick centered
    send_beat(FUNC_AXIS, AXIS_X, 16'h000A);   // rounds to zero
    send_beat(FUNC_AXIS, AXIS_Y, 16'h000B);   // rounds to one
    send_tick();
    send_beat(FUNC_AXIS, AXIS_X, 16'hFFF5);
    send_beat(FUNC_AXIS, AXIS_Y, 16'hFFF6);
    send_tick();                              // full left at minimum length
    send_beat(FUNC_AXIS, AXIS_X, 16'h4000);
    send_beat(FUNC_AXIS, AXIS_Y, 16'hC000);
    send_tick();
    send_beat(FUNC_TICK, AXIS_X, 16'h7FFF);

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_limit(2047);
        1: set_limit(0);
        2: set_limit(1);
        3: set_limit($urandom_range(2046, 2));
        4: set_limit(LIMIT_AT_RESET);
        default: set_limit($urandom_range(2047, 800));
      endcase
      case (ph % 4)
        0: begin src_idle_pct = 0; rx_stall_pct = 0; end
        1: begin src_idle_pct = 75; rx_stall_pct = 0; end
        2: begin src_idle_pct = 0; rx_stall_pct = 75; end
        default: begin src_idle_pct = 33; rx_stall_pct = 33; end
      endcase
      target = items_sent + PHASE_ITEMS;
      if (ph == 0) begin
        // output blocked for a while: the input has to back up
        rx_hold_left <= 600;
        repeat (8) send_group();
      end
      while (items_sent < target) begin
        send_group();
        if (ph == 2 && !paused && items_sent > target - PHASE_ITEMS / 2) begin
          settle();
          paused = 1;
        end
      end
    end

    settle();
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
